// ----- hdl/deploy_burn_sequencer_core_defines.svh -----
// Assertion helpers for the deployment sequencer. Both expect clk and rst_n in scope.
`ifndef DEPLOY_BURN_SEQUENCER_CORE_DEFINES_SVH
`define DEPLOY_BURN_SEQUENCER_CORE_DEFINES_SVH

// expression must hold at every edge out of reset
`define DBS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dbs_pkg.sv -----
package dbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int W_SEC = 20;
  localparam int W_CYC = 8;
  localparam int W_PH  = 3;
  localparam int W_CMD = 3;
  localparam int W_REQ = 2;
  localparam int W_RPH = 8;
  localparam int W_REL = 32;
  localparam int W_CFX = 3;
  localparam int W_KND = 2;

  // request codes
  localparam logic [W_REQ-1:0] REQ_TICK     = 2'd0;
  localparam logic [W_REQ-1:0] REQ_START    = 2'd1;
  localparam logic [W_REQ-1:0] REQ_COMPLETE = 2'd2;

  // classified item kinds
  localparam logic [W_KND-1:0] KIND_TICK  = 2'd0;
  localparam logic [W_KND-1:0] KIND_START = 2'd1;
  localparam logic [W_KND-1:0] KIND_ABORT = 2'd2;
  localparam logic [W_KND-1:0] KIND_NONE  = 2'd3;

  // result commands
  localparam logic [W_CMD-1:0] CMD_STATUS   = 3'd0;
  localparam logic [W_CMD-1:0] CMD_DETUMBLE = 3'd1;
  localparam logic [W_CMD-1:0] CMD_BURN_ON  = 3'd2;
  localparam logic [W_CMD-1:0] CMD_BURN_OFF = 3'd3;
  localparam logic [W_CMD-1:0] CMD_TLM_EN   = 3'd4;
  localparam logic [W_CMD-1:0] CMD_SAVE     = 3'd5;
  localparam logic [W_CMD-1:0] CMD_DEFAULTS = 3'd6;

  // sequencer phases
  localparam logic [W_PH-1:0] PH_IDLE = 3'd0;
  localparam logic [W_PH-1:0] PH_INIT = 3'd1;
  localparam logic [W_PH-1:0] PH_BURN = 3'd2;
  localparam logic [W_PH-1:0] PH_TOEN = 3'd3;
  localparam logic [W_PH-1:0] PH_POST = 3'd4;
  localparam logic [W_PH-1:0] PH_DONE = 3'd5;

  // phase codes inside a stored snapshot
  localparam logic [W_RPH-1:0] RPH_INIT = 8'd0;
  localparam logic [W_RPH-1:0] RPH_BURN = 8'd1;
  localparam logic [W_RPH-1:0] RPH_POST = 8'd3;
  localparam logic [W_RPH-1:0] RPH_DONE = 8'd4;

  // register indexes
  localparam logic [W_CFX-1:0] CFG_INIT_WAIT = 3'd0;
  localparam logic [W_CFX-1:0] CFG_BURN      = 3'd1;
  localparam logic [W_CFX-1:0] CFG_POST_WAIT = 3'd2;
  localparam logic [W_CFX-1:0] CFG_REPEAT    = 3'd3;
  localparam logic [W_CFX-1:0] CFG_SAVE_INT  = 3'd4;
  localparam logic [W_CFX-1:0] CFG_DETUMBLE  = 3'd5;

  localparam logic [W_SEC-1:0] RST_INIT_WAIT = 20'd1800;
  localparam logic [W_SEC-1:0] RST_BURN      = 20'd30;
  localparam logic [W_SEC-1:0] RST_POST_WAIT = 20'd600;
  localparam logic [W_CYC-1:0] RST_REPEAT    = 8'd3;
  localparam logic [W_SEC-1:0] RST_SAVE_INT  = 20'd60;
  localparam logic             RST_DETUMBLE  = 1'b1;

  typedef struct packed {
    logic [W_SEC-1:0] init_wait;
    logic [W_SEC-1:0] burn;
    logic [W_SEC-1:0] post_wait;
    logic [W_CYC-1:0] repeat_cnt;
    logic [W_SEC-1:0] save_int;
    logic             detumble;
  } cfg_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic [W_KND-1:0] kind;
    logic             bad;
    logic [W_PH-1:0]  rph;
    logic [W_CYC-1:0] cyc;
    logic [W_SEC-1:0] elap;
  } fitem_t;

  typedef struct packed {
    logic [W_CMD-1:0] command;
    logic [W_PH-1:0]  phase;
    logic [W_CYC-1:0] cycles_done;
    logic [W_SEC-1:0] wait_elapsed;
    logic [W_SEC-1:0] wait_remaining;
    logic             last;
  } res_t;

  typedef struct packed {
    logic            idle;
    logic            held;
    logic            abort;
    logic [W_PH-1:0] phase;
  } bstat_t;

endpackage

// ----- hdl/dbs_in_if.sv -----
interface dbs_in_if import dbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [W_REQ-1:0] req_type;
  logic             resume_intact;
  logic [W_RPH-1:0] resume_phase;
  logic [W_CYC-1:0] resume_cycles;
  logic [W_REL-1:0] resume_elapsed;

  modport source (
    output valid, req_type, resume_intact, resume_phase, resume_cycles, resume_elapsed,
    input  ready
  );
  modport sink (
    input  valid, req_type, resume_intact, resume_phase, resume_cycles, resume_elapsed,
    output ready
  );
endinterface

// ----- hdl/dbs_out_if.sv -----
interface dbs_out_if import dbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [W_CMD-1:0] command;
  logic [W_PH-1:0]  phase;
  logic [W_CYC-1:0] cycles_done;
  logic [W_SEC-1:0] wait_elapsed;
  logic [W_SEC-1:0] wait_remaining;
  logic             last;

  modport source (
    output valid, command, phase, cycles_done, wait_elapsed, wait_remaining, last,
    input  ready
  );
  modport sink (
    input  valid, command, phase, cycles_done, wait_elapsed, wait_remaining, last,
    output ready
  );
endinterface

// ----- hdl/dbs_front.sv -----
module dbs_front import dbs_pkg::*; (
  dbs_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output fitem_t   item
);

  logic [W_SEC-1:0] rd;
  logic             bad;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // allowed elapsed time for the snapshot's phase
  always_comb begin
    case (in_ch.resume_phase)
      RPH_INIT: rd = cfg.init_wait;
      RPH_BURN: rd = cfg.burn;
      RPH_POST: rd = cfg.post_wait;
      default:  rd = '0;
    endcase
  end

  always_comb begin
    bad = !in_ch.resume_intact
       || (in_ch.resume_cycles > cfg.repeat_cnt)
       || (in_ch.resume_phase > RPH_DONE)
       || (in_ch.resume_phase == RPH_INIT && in_ch.resume_cycles != '0)
       || (in_ch.resume_phase == RPH_DONE && in_ch.resume_cycles != cfg.repeat_cnt)
       || (in_ch.resume_phase != RPH_DONE && in_ch.resume_cycles >= cfg.repeat_cnt)
       || (in_ch.resume_elapsed > {{(W_REL-W_SEC){1'b0}}, rd});
  end

  always_comb begin
    case (in_ch.req_type)
      REQ_TICK:     item.kind = KIND_TICK;
      REQ_START:    item.kind = KIND_START;
      REQ_COMPLETE: item.kind = KIND_ABORT;
      default:      item.kind = KIND_NONE;
    endcase
    item.bad  = bad;
    // snapshot phase code maps to sequencer phase by +1 (only used when valid)
    item.rph  = in_ch.resume_phase[W_PH-1:0] + W_PH'(1);
    item.cyc  = in_ch.resume_cycles;
    item.elap = in_ch.resume_elapsed[W_SEC-1:0];
  end

endmodule

// ----- hdl/dbs_queue.sv -----
module dbs_queue import dbs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  fitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output fitem_t head_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fitem_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hdl/dbs_back.sv -----
module dbs_back import dbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  fitem_t    head_item,
  output logic      pop,
  dbs_out_if.source out_ch,
  output bstat_t    bstat
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_TICK     = 5'd1;
  localparam logic [4:0] S_INIT_END = 5'd2;
  localparam logic [4:0] S_SC       = 5'd3;
  localparam logic [4:0] S_EB0      = 5'd4;
  localparam logic [4:0] S_EB1      = 5'd5;
  localparam logic [4:0] S_EB2      = 5'd6;
  localparam logic [4:0] S_EB3      = 5'd7;
  localparam logic [4:0] S_EB4      = 5'd8;
  localparam logic [4:0] S_EPW      = 5'd9;
  localparam logic [4:0] S_ST0      = 5'd10;
  localparam logic [4:0] S_ST1      = 5'd11;
  localparam logic [4:0] S_ST2      = 5'd12;
  localparam logic [4:0] S_ST3      = 5'd13;
  localparam logic [4:0] S_CP0      = 5'd14;
  localparam logic [4:0] S_CP1      = 5'd15;
  localparam logic [4:0] S_CP2      = 5'd16;
  localparam logic [4:0] S_END      = 5'd17;

  function automatic logic [W_SEC-1:0] wait_len(input logic [W_PH-1:0] ph, input cfg_t c);
    logic [W_SEC-1:0] d;
    case (ph)
      PH_INIT: d = c.init_wait;
      PH_BURN: d = c.burn;
      PH_POST: d = c.post_wait;
      default: d = '0;
    endcase
    return d;
  endfunction

  // first step for a freshly popped item
  function automatic logic [4:0] dispatch(input logic [W_KND-1:0] kind,
                                          input logic [W_PH-1:0] ph);
    logic [4:0] s;
    case (kind)
      KIND_TICK:  s = (ph inside {PH_INIT, PH_BURN, PH_POST}) ? S_TICK : S_END;
      KIND_START: s = (ph inside {PH_INIT, PH_BURN, PH_TOEN, PH_POST}) ? S_END : S_ST0;
      KIND_ABORT: s = S_CP0;
      default:    s = S_END;
    endcase
    return s;
  endfunction

  logic [4:0]       st_r, st_nxt;
  logic [W_PH-1:0]  phase_r, phase_nxt;
  logic [W_CYC-1:0] cyc_r, cyc_nxt;
  logic [W_SEC-1:0] elap_r, elap_nxt;
  logic [W_SEC:0]   mark_r, mark_nxt;
  logic             abort_r, abort_nxt;
  logic [W_PH-1:0]  prev_r, prev_nxt;
  fitem_t           cur_r, cur_nxt;
  logic             held_v_r, held_v_nxt;
  res_t             held_r, held_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             out_r, out_nxt;

  logic             go;
  logic             emit;
  logic             fin;
  logic [W_CMD-1:0] emit_cmd;
  res_t             res_new;

  // tick arithmetic on the current wait
  logic [W_SEC-1:0] d_cur;
  logic [W_SEC:0]   inc;
  logic             t_done;
  logic [W_SEC-1:0] t_elap;
  logic             t_save;
  logic [W_CYC-1:0] cyc_inc;
  logic [W_SEC-1:0] d_nxt;

  assign go      = !out_v_r || out_ch.ready;
  assign d_cur   = wait_len(phase_r, cfg);
  assign inc     = {1'b0, elap_r} + (W_SEC+1)'(1);
  assign t_done  = (inc >= {1'b0, d_cur});
  assign t_elap  = t_done ? d_cur : inc[W_SEC-1:0];
  assign t_save  = t_done || ({1'b0, t_elap} >= mark_r);
  assign cyc_inc = cyc_r + W_CYC'(1);

  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    cyc_nxt   = cyc_r;
    elap_nxt  = elap_r;
    mark_nxt  = mark_r;
    abort_nxt = abort_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    pop       = 1'b0;
    emit      = 1'b0;
    fin       = 1'b0;
    emit_cmd  = CMD_STATUS;

    case (st_r)
      S_IDLE: begin
        if (head_valid) begin
          pop     = 1'b1;
          cur_nxt = head_item;
          st_nxt  = dispatch(head_item.kind, phase_r);
        end
      end

      S_TICK: begin
        if (go) begin
          if (d_cur == '0) begin
            // zero-length wait ends without a save
            st_nxt = (phase_r == PH_INIT) ? S_INIT_END :
                     (phase_r == PH_BURN) ? S_EB0 : S_EPW;
          end else begin
            elap_nxt = t_elap;
            if (t_save) begin
              emit     = 1'b1;
              emit_cmd = CMD_SAVE;
              mark_nxt = {1'b0, t_elap} + {1'b0, cfg.save_int};
            end
            if (t_done) begin
              st_nxt = (phase_r == PH_INIT) ? S_INIT_END :
                       (phase_r == PH_BURN) ? S_EB0 : S_EPW;
            end else begin
              st_nxt = S_END;
            end
          end
        end
      end

      S_INIT_END: begin
        if (go) begin
          elap_nxt  = '0;
          phase_nxt = PH_BURN;
          emit      = 1'b1;
          emit_cmd  = CMD_SAVE;
          st_nxt    = S_SC;
        end
      end

      S_SC: begin
        if (go) begin
          emit     = 1'b1;
          elap_nxt = '0;
          st_nxt   = S_END;
          if (cyc_r < cfg.repeat_cnt && !abort_r) begin
            phase_nxt = PH_BURN;
            mark_nxt  = {1'b0, cfg.save_int};
            emit_cmd  = CMD_BURN_ON;
          end else begin
            cyc_nxt   = cfg.repeat_cnt;
            phase_nxt = PH_DONE;
            emit_cmd  = CMD_SAVE;
          end
        end
      end

      S_EB0: begin
        if (go) begin
          elap_nxt = '0;
          emit     = 1'b1;
          emit_cmd = CMD_BURN_OFF;
          st_nxt   = S_EB1;
        end
      end

      S_EB1: begin
        if (go) begin
          emit     = 1'b1;
          emit_cmd = CMD_SAVE;
          st_nxt   = S_EB2;
        end
      end

      S_EB2: begin
        if (go) begin
          phase_nxt = PH_TOEN;
          emit      = 1'b1;
          emit_cmd  = CMD_TLM_EN;
          st_nxt    = S_EB3;
        end
      end

      S_EB3: begin
        if (go) begin
          emit     = 1'b1;
          emit_cmd = CMD_SAVE;
          st_nxt   = S_EB4;
        end
      end

      S_EB4: begin
        if (go) begin
          phase_nxt = PH_POST;
          mark_nxt  = {1'b0, cfg.save_int};
          emit      = 1'b1;
          emit_cmd  = CMD_SAVE;
          st_nxt    = (cfg.post_wait == '0) ? S_EPW : S_END;
        end
      end

      S_EPW: begin
        if (go) begin
          elap_nxt  = '0;
          cyc_nxt   = cyc_inc;
          phase_nxt = (cyc_inc < cfg.repeat_cnt) ? PH_BURN : PH_DONE;
          emit      = 1'b1;
          emit_cmd  = CMD_SAVE;
          st_nxt    = S_SC;
        end
      end

      S_ST0: begin
        if (go) begin
          mark_nxt = '0;
          if (cur_r.bad) begin
            phase_nxt = PH_INIT;
            cyc_nxt   = '0;
            elap_nxt  = '0;
            emit      = 1'b1;
            emit_cmd  = CMD_DEFAULTS;
            st_nxt    = S_ST1;
          end else begin
            phase_nxt = cur_r.rph;
            cyc_nxt   = cur_r.cyc;
            elap_nxt  = cur_r.elap;
            st_nxt    = S_ST2;
          end
        end
      end

      S_ST1: begin
        if (go) begin
          emit     = 1'b1;
          emit_cmd = CMD_SAVE;
          st_nxt   = S_ST2;
        end
      end

      S_ST2: begin
        if (go) begin
          emit     = cfg.detumble;
          emit_cmd = CMD_DETUMBLE;
          st_nxt   = S_ST3;
        end
      end

      S_ST3: begin
        if (go) begin
          if (phase_r == PH_DONE) begin
            emit     = 1'b1;
            emit_cmd = CMD_TLM_EN;
            st_nxt   = S_END;
          end else if (abort_r) begin
            elap_nxt  = '0;
            cyc_nxt   = cfg.repeat_cnt;
            phase_nxt = PH_DONE;
            emit      = 1'b1;
            emit_cmd  = CMD_SAVE;
            st_nxt    = S_END;
          end else if (phase_r == PH_INIT) begin
            if (elap_r >= cfg.init_wait) begin
              st_nxt = S_INIT_END;
            end else begin
              mark_nxt = {1'b0, elap_r} + {1'b0, cfg.save_int};
              st_nxt   = S_END;
            end
          end else begin
            st_nxt = S_SC;
          end
        end
      end

      S_CP0: begin
        if (go) begin
          prev_nxt  = phase_r;
          abort_nxt = 1'b1;
          phase_nxt = PH_DONE;
          cyc_nxt   = cfg.repeat_cnt;
          elap_nxt  = '0;
          emit      = 1'b1;
          emit_cmd  = CMD_SAVE;
          st_nxt    = S_CP1;
        end
      end

      S_CP1: begin
        if (go) begin
          emit     = (prev_r == PH_BURN);
          emit_cmd = CMD_BURN_OFF;
          st_nxt   = S_CP2;
        end
      end

      S_CP2: begin
        if (go) begin
          emit     = (prev_r inside {PH_INIT, PH_BURN, PH_TOEN, PH_POST});
          emit_cmd = CMD_SAVE;
          st_nxt   = S_END;
        end
      end

      S_END: begin
        if (go) begin
          fin = 1'b1;
          if (head_valid) begin
            pop     = 1'b1;
            cur_nxt = head_item;
            st_nxt  = dispatch(head_item.kind, phase_r);
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // result fields reflect the state right after the step
  assign d_nxt = wait_len(phase_nxt, cfg);

  always_comb begin
    res_new.command        = emit_cmd;
    res_new.phase          = phase_nxt;
    res_new.cycles_done    = cyc_nxt;
    res_new.wait_elapsed   = elap_nxt;
    res_new.wait_remaining = (elap_nxt < d_nxt) ? (d_nxt - elap_nxt) : '0;
    res_new.last           = 1'b0;
  end

  // the newest result waits in held_r until we know whether it is the item's last
  always_comb begin
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_nxt    = out_r;
    if (emit) begin
      if (held_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = held_r;
      end
      held_v_nxt = 1'b1;
      held_nxt   = res_new;
    end else if (fin) begin
      out_v_nxt  = 1'b1;
      out_nxt    = held_v_r ? held_r : res_new;
      out_nxt.last = 1'b1;
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      phase_r  <= PH_IDLE;
      cyc_r    <= '0;
      elap_r   <= '0;
      mark_r   <= '0;
      abort_r  <= 1'b0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      cyc_r    <= cyc_nxt;
      elap_r   <= elap_nxt;
      mark_r   <= mark_nxt;
      abort_r  <= abort_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.command        = out_r.command;
  assign out_ch.phase          = out_r.phase;
  assign out_ch.cycles_done    = out_r.cycles_done;
  assign out_ch.wait_elapsed   = out_r.wait_elapsed;
  assign out_ch.wait_remaining = out_r.wait_remaining;
  assign out_ch.last           = out_r.last;

  assign bstat.idle  = (st_r == S_IDLE);
  assign bstat.held  = held_v_r;
  assign bstat.abort = abort_r;
  assign bstat.phase = phase_r;

endmodule

// ----- hdl/deploy_burn_sequencer_core.sv -----
// Deployment burn sequencer. Items on in_ch are one-second ticks, starts carrying a resumed
// snapshot, or completion requests; each item yields one to eight results on out_ch, the
// final one flagged by last. Snapshot checks happen as an item is taken, then the item waits
// in a small queue (QUEUE_DEPTH entries) for the sequencer, which steps one action per cycle
// while its output register is free or out_ch.ready is high, and emits at most one result
// per cycle. An item occupies the sequencer until its last result is formed; the queue keeps
// input accepted meanwhile and an output register lets results wait for out_ch.ready without
// blocking intake. Registers are to be written through cfg_we/cfg_index/cfg_wdata only while
// no item is in flight; the user must keep to this, the block does not enforce it.
`include "deploy_burn_sequencer_core_defines.svh"

module deploy_burn_sequencer_core import dbs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  dbs_in_if.sink           in_ch,
  dbs_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [W_CFX-1:0] cfg_index,
  input  logic [W_SEC-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_hvalid;
  fitem_t q_in;
  fitem_t q_head;
  bstat_t bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_wait  <= RST_INIT_WAIT;
      cfg_r.burn       <= RST_BURN;
      cfg_r.post_wait  <= RST_POST_WAIT;
      cfg_r.repeat_cnt <= RST_REPEAT;
      cfg_r.save_int   <= RST_SAVE_INT;
      cfg_r.detumble   <= RST_DETUMBLE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_WAIT: cfg_r.init_wait  <= cfg_wdata;
        CFG_BURN:      cfg_r.burn       <= cfg_wdata;
        CFG_POST_WAIT: cfg_r.post_wait  <= cfg_wdata;
        CFG_REPEAT:    cfg_r.repeat_cnt <= cfg_wdata[W_CYC-1:0];
        CFG_SAVE_INT:  cfg_r.save_int   <= cfg_wdata;
        CFG_DETUMBLE:  cfg_r.detumble   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dbs_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (q_push),
    .item   (q_in)
  );

  dbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_hvalid),
    .head_item  (q_head)
  );

  dbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_hvalid),
    .head_item  (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch),
    .bstat      (bstat)
  );

  // after an abort every finished item leaves the sequence complete
  `DBS_ASSERT_ALWAYS(a_abort_done, !bstat.idle || !bstat.abort || bstat.phase == PH_DONE, "abort left sequence running")
  `DBS_ASSERT_NEXT(a_abort_sticky, bstat.abort, bstat.abort, "abort flag cleared")
  // a result still held when the sequencer goes idle would be lost
  `DBS_ASSERT_ALWAYS(a_idle_no_held, !bstat.idle || !bstat.held, "held result while idle")

endmodule
